[rtl/i2cms_pkg.sv]
// shared types, codes and phase helpers for the i2c master byte sequencer
// no dependencies; used by i2cms_core, i2cms_out_buf and the top level
package i2cms_pkg;

  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] LONG_WAIT_RST   = 10'd5;
  localparam logic [CFG_W-1:0] SHORT_WAIT_RST  = 10'd2;
  localparam logic [CFG_W-1:0] SAMPLE_WAIT_RST = 10'd1;
  localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 10'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LONG_WAIT   = 2'd0,
    CFG_SHORT_WAIT  = 2'd1,
    CFG_SAMPLE_WAIT = 2'd2,
    CFG_ACK_TIMEOUT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_WRITE    = 3'd3,
    CMD_READ     = 3'd4,
    CMD_WAIT_ACK = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_SP_C    = 5'd5,
    PH_WR_SET  = 5'd6,
    PH_WR_HI   = 5'd7,
    PH_WR_LO   = 5'd8,
    PH_RD_LO   = 5'd9,
    PH_RD_HI   = 5'd10,
    PH_AK_LO   = 5'd11,
    PH_AK_HI   = 5'd12,
    PH_WA_A    = 5'd13,
    PH_WA_B    = 5'd14,
    PH_WA_POLL = 5'd15
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_wait;
    logic [CFG_W-1:0] short_wait;
    logic [CFG_W-1:0] sample_wait;
    logic [CFG_W-1:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       bit_cnt;
    logic [7:0]       shift;
    logic [CFG_W-1:0] delay;
    logic [CFG_W-1:0] poll;
    logic             scl;
    logic             sda;
    logic             sda_oe;
    logic             ack_flag;
    logic             ack_choice;
    logic [7:0]       tx_hold;
  } seq_st_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } res_t;

  // a zero wait is raised to one
  function automatic logic [CFG_W-1:0] hold_of(input logic [CFG_W-1:0] w);
    hold_of = (w == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : w;
  endfunction

  // pin levels and hold time on entry to a phase
  function automatic seq_st_t enter(input seq_st_t s, input phase_t p, input logic sda_in,
                                    input cfg_t cfg);
    seq_st_t n;
    n = s;
    n.phase = p;
    case (p)
      PH_ST_A: begin
        n.sda_oe = 1'b1; n.sda = 1'b1; n.scl = 1'b1; n.delay = hold_of(cfg.long_wait);
      end
      PH_ST_B: begin
        n.sda = 1'b0; n.delay = hold_of(cfg.long_wait);
      end
      PH_SP_A: begin
        n.sda_oe = 1'b1; n.scl = 1'b0; n.sda = 1'b0; n.delay = hold_of(cfg.long_wait);
      end
      PH_SP_B: begin
        n.scl = 1'b1; n.delay = hold_of(cfg.short_wait);
      end
      PH_SP_C: begin
        n.sda = 1'b1; n.delay = hold_of(cfg.long_wait);
      end
      PH_WR_SET: begin
        n.sda_oe = 1'b1; n.scl = 1'b0;
        n.sda = s.tx_hold[~s.bit_cnt[2:0]];
        n.delay = hold_of(cfg.long_wait);
      end
      PH_WR_HI: begin
        n.scl = 1'b1; n.delay = hold_of(cfg.short_wait);
      end
      PH_WR_LO: begin
        n.scl = 1'b0; n.delay = hold_of(cfg.short_wait);
      end
      PH_RD_LO: begin
        n.sda_oe = 1'b0; n.scl = 1'b0; n.delay = hold_of(cfg.short_wait);
      end
      PH_RD_HI: begin
        n.scl = 1'b1;
        n.shift = {s.shift[6:0], sda_in};
        n.delay = hold_of(cfg.sample_wait);
      end
      PH_AK_LO: begin
        n.scl = 1'b0; n.sda_oe = 1'b1; n.sda = ~s.ack_choice;
        n.delay = hold_of(cfg.short_wait);
      end
      PH_AK_HI: begin
        n.scl = 1'b1; n.delay = hold_of(cfg.short_wait);
      end
      PH_WA_A: begin
        n.sda_oe = 1'b0; n.sda = 1'b1; n.poll = '0; n.delay = hold_of(cfg.sample_wait);
      end
      PH_WA_B: begin
        n.scl = 1'b1; n.delay = hold_of(cfg.sample_wait);
      end
      default: begin
        n.delay = '0;
      end
    endcase
    enter = n;
  endfunction

endpackage

[rtl/i2cms_core.sv]
// sequencer state register and per-tick next-state logic
// depends on i2cms_pkg
module i2cms_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [2:0]          cmd,
  input  logic [7:0]          tx_byte,
  input  logic                send_ack,
  input  logic                sda_sample,
  input  i2cms_pkg::cfg_t     cfg,
  output i2cms_pkg::res_t     res
);

  i2cms_pkg::seq_st_t st_r;
  i2cms_pkg::seq_st_t st_nxt;
  logic               done;

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    if (st_r.phase == i2cms_pkg::PH_IDLE) begin
      st_nxt.bit_cnt = '0;
      case (cmd)
        i2cms_pkg::CMD_START: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_ST_A, sda_sample, cfg);
        end
        i2cms_pkg::CMD_STOP: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_SP_A, sda_sample, cfg);
        end
        i2cms_pkg::CMD_WRITE: begin
          st_nxt.tx_hold = tx_byte;
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WR_SET, sda_sample, cfg);
        end
        i2cms_pkg::CMD_READ: begin
          st_nxt.ack_choice = send_ack;
          st_nxt.shift      = '0;
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_RD_LO, sda_sample, cfg);
        end
        i2cms_pkg::CMD_WAIT_ACK: begin
          st_nxt.ack_flag = 1'b0;
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WA_A, sda_sample, cfg);
        end
        default: begin
        end
      endcase
    end else if (st_r.phase == i2cms_pkg::PH_WA_POLL) begin
      if (!sda_sample) begin
        st_nxt.scl      = 1'b0;
        st_nxt.ack_flag = 1'b0;
        st_nxt.phase    = i2cms_pkg::PH_IDLE;
        done            = 1'b1;
      end else if (st_r.poll >= cfg.ack_timeout) begin
        // no acknowledge in time: flag it and run a full stop
        st_nxt.ack_flag = 1'b1;
        st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_SP_A, sda_sample, cfg);
      end else begin
        st_nxt.poll = st_r.poll + 10'd1;
      end
    end else if (st_r.delay > 10'd1) begin
      st_nxt.delay = st_r.delay - 10'd1;
    end else begin
      case (st_r.phase)
        i2cms_pkg::PH_ST_A: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_ST_B, sda_sample, cfg);
        end
        i2cms_pkg::PH_ST_B: begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = i2cms_pkg::PH_IDLE;
          done         = 1'b1;
        end
        i2cms_pkg::PH_SP_A: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_SP_B, sda_sample, cfg);
        end
        i2cms_pkg::PH_SP_B: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_SP_C, sda_sample, cfg);
        end
        i2cms_pkg::PH_WR_SET: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WR_HI, sda_sample, cfg);
        end
        i2cms_pkg::PH_WR_HI: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WR_LO, sda_sample, cfg);
        end
        i2cms_pkg::PH_WR_LO: begin
          st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
          if (st_nxt.bit_cnt < 4'd8) begin
            st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WR_SET, sda_sample, cfg);
          end else begin
            st_nxt.phase = i2cms_pkg::PH_IDLE;
            done         = 1'b1;
          end
        end
        i2cms_pkg::PH_RD_LO: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_RD_HI, sda_sample, cfg);
        end
        i2cms_pkg::PH_RD_HI: begin
          st_nxt.bit_cnt = st_r.bit_cnt + 4'd1;
          if (st_nxt.bit_cnt < 4'd8) begin
            st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_RD_LO, sda_sample, cfg);
          end else begin
            st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_AK_LO, sda_sample, cfg);
          end
        end
        i2cms_pkg::PH_AK_LO: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_AK_HI, sda_sample, cfg);
        end
        i2cms_pkg::PH_AK_HI: begin
          st_nxt.scl   = 1'b0;
          st_nxt.phase = i2cms_pkg::PH_IDLE;
          done         = 1'b1;
        end
        i2cms_pkg::PH_WA_A: begin
          st_nxt = i2cms_pkg::enter(st_nxt, i2cms_pkg::PH_WA_B, sda_sample, cfg);
        end
        i2cms_pkg::PH_WA_B: begin
          st_nxt.phase = i2cms_pkg::PH_WA_POLL;
          st_nxt.delay = '0;
        end
        default: begin
          // end of stop
          st_nxt.phase = i2cms_pkg::PH_IDLE;
          done         = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_level        = st_nxt.scl;
    res.sda_level        = st_nxt.sda;
    res.sda_drive_enable = st_nxt.sda_oe;
    res.busy_res         = (st_nxt.phase != i2cms_pkg::PH_IDLE);
    res.done_res         = done;
    res.rx_byte          = st_nxt.shift;
    res.ack_missing      = st_nxt.ack_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= i2cms_pkg::PH_IDLE;
      st_r.bit_cnt    <= '0;
      st_r.shift      <= '0;
      st_r.delay      <= '0;
      st_r.poll       <= '0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.sda_oe     <= 1'b1;
      st_r.ack_flag   <= 1'b0;
      st_r.ack_choice <= 1'b0;
      st_r.tx_hold    <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/i2cms_out_buf.sv]
// result register between the sequencer and the output channel
// depends on i2cms_pkg
module i2cms_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  i2cms_pkg::res_t res,
  output logic            load_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cms_pkg::res_t out_res
);

  logic            valid_r;
  i2cms_pkg::res_t data_r;

  // a new result may enter while the held one is being taken
  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

[rtl/i2c_master_byte_sequencer.sv]
// i2c master byte sequencer top level: one tick transfer in, one pin/status transfer out
// output: the result of a tick transfer is registered and shown in the cycle after it is accepted
// throughput: one tick per cycle while the output register is empty or out_tready is high
// reset: rst_n synchronous active low; bus idle (scl, sda high, sda driven), wait registers
//   back to 5, 2, 1 and 255, output register empty
// depends on i2cms_pkg, i2cms_core, i2cms_out_buf
module i2c_master_byte_sequencer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tick channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata: cmd[2:0], tx_byte[10:3], send_ack[11], sda_sample[12], zero fill
  input  logic [i2cms_pkg::IN_DATA_W-1:0]       in_tdata,
  // result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata: scl_level[0], sda_level[1], sda_drive_enable[2], busy_res[3], done_res[4],
  //        rx_byte[12:5], ack_missing[13], zero fill
  output logic [i2cms_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [i2cms_pkg::CFG_W-1:0]           cfg_wdata
);

  i2cms_pkg::cfg_t cfg_r;
  i2cms_pkg::res_t step_res;
  i2cms_pkg::res_t held_res;
  logic            in_xfer;
  logic            buf_ready;

  // wait and timeout registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_wait   <= i2cms_pkg::LONG_WAIT_RST;
      cfg_r.short_wait  <= i2cms_pkg::SHORT_WAIT_RST;
      cfg_r.sample_wait <= i2cms_pkg::SAMPLE_WAIT_RST;
      cfg_r.ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        i2cms_pkg::CFG_LONG_WAIT:   cfg_r.long_wait   <= cfg_wdata;
        i2cms_pkg::CFG_SHORT_WAIT:  cfg_r.short_wait  <= cfg_wdata;
        i2cms_pkg::CFG_SAMPLE_WAIT: cfg_r.sample_wait <= cfg_wdata;
        i2cms_pkg::CFG_ACK_TIMEOUT: cfg_r.ack_timeout <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // a tick is taken whenever the result register can hold its answer
  assign in_tready = buf_ready;
  assign in_xfer   = in_tvalid && in_tready;

  i2cms_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_xfer),
    .cmd        (in_tdata[2:0]),
    .tx_byte    (in_tdata[10:3]),
    .send_ack   (in_tdata[11]),
    .sda_sample (in_tdata[12]),
    .cfg        (cfg_r),
    .res        (step_res)
  );

  i2cms_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .res        (step_res),
    .load_ready (buf_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (held_res)
  );

  // pack result fields, lowest bit last in the list
  assign out_tdata = {2'b00,
                      held_res.ack_missing,
                      held_res.rx_byte,
                      held_res.done_res,
                      held_res.busy_res,
                      held_res.sda_drive_enable,
                      held_res.sda_level,
                      held_res.scl_level};

endmodule
